@@ rtl/bthc_pkg.sv @@
// shared types and constants for the bcd twelve-hour clock
// no dependencies; imported by every module of the block
package bthc_pkg;

    localparam int LEVEL_W = 10;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [1:0]
    {
        OP_TICK = 2'd0,
        OP_KEY  = 2'd1,
        OP_LOAD = 2'd2
    } op_t;

    typedef enum logic [2:0]
    {
        BTN_NONE   = 3'd0,
        BTN_RIGHT  = 3'd1,
        BTN_UP     = 3'd2,
        BTN_DOWN   = 3'd3,
        BTN_LEFT   = 3'd4,
        BTN_SELECT = 3'd5
    } button_t;

    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_ABOVE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_BELOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_BELOW     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_BELOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_BELOW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SELECT_BELOW = 3'd5;

    localparam logic [LEVEL_W-1:0] RST_IDLE_ABOVE   = 10'd1000;
    localparam logic [LEVEL_W-1:0] RST_RIGHT_BELOW  = 10'd50;
    localparam logic [LEVEL_W-1:0] RST_UP_BELOW     = 10'd150;
    localparam logic [LEVEL_W-1:0] RST_DOWN_BELOW   = 10'd300;
    localparam logic [LEVEL_W-1:0] RST_LEFT_BELOW   = 10'd450;
    localparam logic [LEVEL_W-1:0] RST_SELECT_BELOW = 10'd700;

    typedef struct packed
    {
        logic [LEVEL_W-1:0] idle_above;
        logic [LEVEL_W-1:0] right_below;
        logic [LEVEL_W-1:0] up_below;
        logic [LEVEL_W-1:0] down_below;
        logic [LEVEL_W-1:0] left_below;
        logic [LEVEL_W-1:0] select_below;
    } key_thr_t;

    typedef struct packed
    {
        logic       hr_tens;
        logic [3:0] hr_ones;
        logic [2:0] min_tens;
        logic [3:0] min_ones;
        logic [2:0] sec_tens;
        logic [3:0] sec_ones;
        logic       am;
        logic       colon;
        logic       light;
    } clock_state_t;

    typedef struct packed
    {
        op_t                op;
        logic [LEVEL_W-1:0] key_level;
        logic               hr_tens;
        logic [3:0]         hr_ones;
        logic [2:0]         min_tens;
        logic [3:0]         min_ones;
        logic [2:0]         sec_tens;
        logic [3:0]         sec_ones;
        logic               am;
    } item_t;

endpackage

@@ rtl/bthc_key_class.sv @@
// sorts a keypad ladder level into a button code against the thresholds
// depends on bthc_pkg
module bthc_key_class
(
    input  logic [bthc_pkg::LEVEL_W-1:0] level,
    input  bthc_pkg::key_thr_t           thr,
    output bthc_pkg::button_t            button
);
    import bthc_pkg::*;

    always_comb
    begin
        if (level > thr.idle_above)
            button = BTN_NONE;
        else if (level < thr.right_below)
            button = BTN_RIGHT;
        else if (level < thr.up_below)
            button = BTN_UP;
        else if (level < thr.down_below)
            button = BTN_DOWN;
        else if (level < thr.left_below)
            button = BTN_LEFT;
        else if (level < thr.select_below)
            button = BTN_SELECT;
        else
            button = BTN_NONE;
    end

endmodule

@@ rtl/bthc_time_core.sv @@
// time-of-day state registers and the per-beat update logic
// depends on bthc_pkg and bthc_key_class
module bthc_time_core
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  bthc_pkg::item_t        item,
    input  bthc_pkg::key_thr_t     thr,
    output bthc_pkg::clock_state_t state_next
);
    import bthc_pkg::*;

    clock_state_t state_reg;
    button_t      last_reg;
    button_t      last_next;
    button_t      button;

    // minute step
    logic       min_wrap;
    logic [3:0] min_ones_inc;
    logic [2:0] min_tens_inc;

    // hour step
    logic [4:0] hr_ones_tmp;
    logic       hr_tens_tmp;
    logic       hr_flip;
    logic [3:0] hr_ones_inc;
    logic       hr_tens_inc;

    bthc_key_class u_key_class
    (
        .level  (item.key_level),
        .thr    (thr),
        .button (button)
    );

    always_comb
    begin
        min_wrap     = 1'b0;
        min_tens_inc = state_reg.min_tens;
        if (state_reg.min_ones >= 4'd9)
        begin
            min_ones_inc = 4'd0;
            if (state_reg.min_tens >= 3'd5)
            begin
                min_tens_inc = 3'd0;
                min_wrap     = 1'b1;
            end
            else
            begin
                min_tens_inc = state_reg.min_tens + 3'd1;
            end
        end
        else
        begin
            min_ones_inc = state_reg.min_ones + 4'd1;
        end
    end

    always_comb
    begin
        hr_ones_tmp = {1'b0, state_reg.hr_ones} + 5'd1;
        hr_tens_tmp = state_reg.hr_tens;
        hr_flip     = 1'b0;
        if (hr_ones_tmp > 5'd9 && !hr_tens_tmp)
        begin
            hr_ones_tmp = 5'd0;
            hr_tens_tmp = 1'b1;
        end
        if (hr_ones_tmp > 5'd2 && hr_tens_tmp)
        begin
            hr_ones_tmp = 5'd1;
            hr_tens_tmp = 1'b0;
            hr_flip     = 1'b1;
        end
        hr_ones_inc = hr_ones_tmp[3:0];
        hr_tens_inc = hr_tens_tmp;
    end

    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        case (item.op)
            OP_TICK:
            begin
                state_next.colon = ~state_reg.colon;
                if (state_reg.sec_ones >= 4'd9)
                begin
                    state_next.sec_ones = 4'd0;
                    if (state_reg.sec_tens >= 3'd5)
                    begin
                        state_next.sec_tens = 3'd0;
                        state_next.min_ones = min_ones_inc;
                        state_next.min_tens = min_tens_inc;
                        if (min_wrap)
                        begin
                            state_next.hr_ones = hr_ones_inc;
                            state_next.hr_tens = hr_tens_inc;
                            state_next.am      = state_reg.am ^ hr_flip;
                        end
                    end
                    else
                    begin
                        state_next.sec_tens = state_reg.sec_tens + 3'd1;
                    end
                end
                else
                begin
                    state_next.sec_ones = state_reg.sec_ones + 4'd1;
                end
            end
            OP_KEY:
            begin
                if (button != last_reg)
                begin
                    case (button)
                        BTN_RIGHT:
                        begin
                            last_next           = button;
                            state_next.min_ones = min_ones_inc;
                            state_next.min_tens = min_tens_inc;
                        end
                        BTN_LEFT:
                        begin
                            last_next          = button;
                            state_next.hr_ones = hr_ones_inc;
                            state_next.hr_tens = hr_tens_inc;
                            state_next.am      = state_reg.am ^ hr_flip;
                        end
                        BTN_SELECT:
                        begin
                            last_next        = button;
                            state_next.light = ~state_reg.light;
                        end
                        BTN_NONE:
                        begin
                            last_next = button;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            OP_LOAD:
            begin
                state_next.hr_tens  = item.hr_tens;
                state_next.hr_ones  = item.hr_ones;
                state_next.min_tens = item.min_tens;
                state_next.min_ones = item.min_ones;
                state_next.sec_tens = item.sec_tens;
                state_next.sec_ones = item.sec_ones;
                state_next.am       = item.am;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.hr_tens  <= 1'b0;
            state_reg.hr_ones  <= 4'd1;
            state_reg.min_tens <= 3'd0;
            state_reg.min_ones <= 4'd0;
            state_reg.sec_tens <= 3'd0;
            state_reg.sec_ones <= 4'd0;
            state_reg.am       <= 1'b1;
            state_reg.colon    <= 1'b1;
            state_reg.light    <= 1'b1;
            last_reg           <= BTN_NONE;
        end
        else if (fire)
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> ($stable(state_reg) && $stable(last_reg)))
        else $error("clock state moved without a beat");

    a_colon_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.op == OP_TICK) |=> (state_reg.colon != $past(state_reg.colon)))
        else $error("colon did not toggle on a tick");

    a_light_key_only: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.op != OP_KEY) |=> $stable(state_reg.light))
        else $error("backlight changed on a non-button beat");

    a_last_no_updown: assert property (@(posedge clk) disable iff (!rst_n)
        (last_reg != BTN_UP && last_reg != BTN_DOWN))
        else $error("up or down stored as last button");

endmodule

@@ rtl/bcd_twelve_hour_clock_top.sv @@
// top level of the bcd twelve-hour clock: channels, threshold registers, result register
// depends on bthc_pkg and bthc_time_core
//
// The block takes one input beat per clock cycle while the output side is not stalled
// and returns exactly one result beat per input beat, showing the time, AM/PM, colon
// and backlight after that beat. A beat is held in the input register and then moves
// to the result register, from which the result is presented. The digit update is a
// single pass of logic against the state registers, which sets the one-beat-per-cycle
// rate. The user must write the threshold registers through cfg_we, cfg_index and
// cfg_data only while no beat is in flight; the block itself does not enforce this.
module bcd_twelve_hour_clock_top
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        operation,
    input  logic [bthc_pkg::LEVEL_W-1:0]      key_level,
    input  logic                              set_hour_tens,
    input  logic [3:0]                        set_hour_ones,
    input  logic [2:0]                        set_minute_tens,
    input  logic [3:0]                        set_minute_ones,
    input  logic [2:0]                        set_second_tens,
    input  logic [3:0]                        set_second_ones,
    input  logic                              set_is_am,

    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              hour_tens,
    output logic [3:0]                        hour_ones,
    output logic [2:0]                        minute_tens,
    output logic [3:0]                        minute_ones,
    output logic [2:0]                        second_tens,
    output logic [3:0]                        second_ones,
    output logic                              is_am,
    output logic                              colon_on,
    output logic                              backlight_on,

    input  logic                              cfg_we,
    input  logic [bthc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bthc_pkg::LEVEL_W-1:0]      cfg_data
);
    import bthc_pkg::*;

    key_thr_t     thr_reg;
    logic         s1_valid_reg;
    logic         s1_valid_next;
    item_t        item_reg;
    logic         out_valid_reg;
    logic         out_valid_next;
    clock_state_t result_reg;
    clock_state_t state_next;
    logic         advance;

    assign advance        = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready       = !s1_valid_reg || advance;
    assign s1_valid_next  = (in_valid && in_ready) || (s1_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !out_ready);

    bthc_time_core u_time_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (advance),
        .item       (item_reg),
        .thr        (thr_reg),
        .state_next (state_next)
    );

    // threshold registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg.idle_above   <= RST_IDLE_ABOVE;
            thr_reg.right_below  <= RST_RIGHT_BELOW;
            thr_reg.up_below     <= RST_UP_BELOW;
            thr_reg.down_below   <= RST_DOWN_BELOW;
            thr_reg.left_below   <= RST_LEFT_BELOW;
            thr_reg.select_below <= RST_SELECT_BELOW;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IDLE_ABOVE:   thr_reg.idle_above   <= cfg_data;
                CFG_RIGHT_BELOW:  thr_reg.right_below  <= cfg_data;
                CFG_UP_BELOW:     thr_reg.up_below     <= cfg_data;
                CFG_DOWN_BELOW:   thr_reg.down_below   <= cfg_data;
                CFG_LEFT_BELOW:   thr_reg.left_below   <= cfg_data;
                CFG_SELECT_BELOW: thr_reg.select_below <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input beat register
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.op        <= op_t'(operation);
            item_reg.key_level <= key_level;
            item_reg.hr_tens   <= set_hour_tens;
            item_reg.hr_ones   <= set_hour_ones;
            item_reg.min_tens  <= set_minute_tens;
            item_reg.min_ones  <= set_minute_ones;
            item_reg.sec_tens  <= set_second_tens;
            item_reg.sec_ones  <= set_second_ones;
            item_reg.am        <= set_is_am;
        end
    end

    // result beat register
    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= state_next;
    end

    assign out_valid    = out_valid_reg;
    assign hour_tens    = result_reg.hr_tens;
    assign hour_ones    = result_reg.hr_ones;
    assign minute_tens  = result_reg.min_tens;
    assign minute_ones  = result_reg.min_ones;
    assign second_tens  = result_reg.sec_tens;
    assign second_ones  = result_reg.sec_ones;
    assign is_am        = result_reg.am;
    assign colon_on     = result_reg.colon;
    assign backlight_on = result_reg.light;

endmodule
